// ===== sv/mfpg_pkg.sv =====
// shared types, constants and arithmetic helpers of the mean flow gradient controller
`timescale 1ns / 1ps
package mfpg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SUM_W = 64;
	localparam int DIV_STEPS = SUM_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int SAT_W = 68;

	localparam int IN_DATA_W = 160;
	localparam int OUT_DATA_W = 256;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [CFG_AW-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_AW-1:0] REG_DIR_X = 3'd1;
	localparam logic [CFG_AW-1:0] REG_DIR_Y = 3'd2;
	localparam logic [CFG_AW-1:0] REG_DIR_Z = 3'd3;
	localparam logic [CFG_AW-1:0] REG_INIT_GRAD = 3'd4;

	localparam logic signed [17:0] DIR_X_RST = 18'sd65536;

	typedef enum logic [1:0] {
		CMD_ACC = 2'd0,
		CMD_FIN = 2'd1,
		CMD_COR = 2'd2,
		CMD_RST = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		MSEL_VEL = 2'd0,
		MSEL_T = 2'd1,
		MSEL_GRAD = 2'd2
	} mul_sel_t;

	typedef enum logic [1:0] {
		DSEL_COEF = 2'd0,
		DSEL_MEAN = 2'd1,
		DSEL_INC = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic accept;
		logic mul_en;
		mul_sel_t mul_sel;
		logic ld_spd;
		logic ld_sc;
		logic sc_cor;
		logic acc_add;
		logic div_start;
		div_sel_t div_sel;
		logic ld_mcoef;
		logic ld_diff;
		logic upd;
		logic err;
		logic restart;
		logic ld_t;
		logic ld_ovel;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_code_t item_cmd;
		logic vol_zero;
		logic quot_zero;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = $signed({{(SAT_W-31){1'b0}}, {31{1'b1}}});
		lo = $signed({{(SAT_W-31){1'b1}}, 31'd0});
		if (x > hi) begin
			return 32'sh7fffffff;
		end else if (x < lo) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// signed result from an unsigned quotient magnitude
	function automatic logic signed [31:0] sdiv_sat(input logic [SUM_W-1:0] q, input logic neg);
		if (neg) begin
			if (q > SUM_W'(64'h80000000)) begin
				return 32'sh80000000;
			end
			return $signed(32'd0 - q[31:0]);
		end
		if (q > SUM_W'(64'h7fffffff)) begin
			return 32'sh7fffffff;
		end
		return $signed(q[31:0]);
	endfunction

endpackage

// ===== sv/mean_flow_pressure_gradient_control_unit.sv =====
// top level of the mean flow pressure gradient controller
`timescale 1ns / 1ps
// Words are taken one at a time: an accumulate, correct, restart or finish word runs through
// its states before the next is accepted, and a finish runs the three divisions in turn on
// the shared one-bit-per-cycle divider; a finish that meets a zero volume sum or a zero mean
// coefficient skips the remaining divisions. A word waits in its last state until the output
// register is free. The next word is taken while a result word still waits in the output
// register.
module mean_flow_pressure_gradient_control_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// cell_volume, vel_x, vel_y, vel_z, inv_diag, zero pad
	input  logic [mfpg_pkg::IN_DATA_W-1:0]     s_tdata,
	// command
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// out_vel_x, out_vel_y, out_vel_z, gradient, increment, source_x, source_y, source_z
	output logic [mfpg_pkg::OUT_DATA_W-1:0]    m_tdata,
	// status
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [mfpg_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [mfpg_pkg::CFG_DW-1:0]        cfg_wdata
);

	mfpg_pkg::ctrl_cmd_t cmd;
	mfpg_pkg::dp_sts_t sts;

	mfpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mfpg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== sv/mfpg_div.sv =====
// restoring divider, one quotient bit per cycle, computes (num * 2^frac) / den saturated
`timescale 1ns / 1ps
module mfpg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mfpg_pkg::SUM_W-1:0]    num,
	input  logic [mfpg_pkg::SUM_W-1:0]    den,
	output logic                          busy,
	output logic [mfpg_pkg::SUM_W-1:0]    quot
);

	logic                             busy_q;
	logic [mfpg_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [mfpg_pkg::SUM_W-1:0]       rem_q;
	logic [mfpg_pkg::SUM_W-1:0]       quo_q;
	logic [mfpg_pkg::SUM_W-1:0]       num_q;
	logic [mfpg_pkg::SUM_W-1:0]       den_q;
	logic                             ovf_q;
	logic [mfpg_pkg::SUM_W-1:0]       rem_sh;
	logic                             take;
	logic                             last;

	assign rem_sh = {rem_q[mfpg_pkg::SUM_W-2:0], num_q[mfpg_pkg::SUM_W-1]};
	assign take = rem_q[mfpg_pkg::SUM_W-1] || (rem_sh >= den_q);
	assign last = (cnt_q == mfpg_pkg::DIV_CNT_W'(mfpg_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? (rem_sh - den_q) : rem_sh;
			quo_q <= {quo_q[mfpg_pkg::SUM_W-2:0], take};
			num_q <= {num_q[mfpg_pkg::SUM_W-2:0], 1'b0};
			if (quo_q[mfpg_pkg::SUM_W-1]) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q;
	assign quot = ovf_q ? '1 : quo_q;

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last && !start) |=> !busy_q)
		else $error("divider did not stop after its last step");

endmodule

// ===== sv/mfpg_dp.sv =====
// datapath: config registers, sums, gradient state, multipliers, divider and output register
`timescale 1ns / 1ps
module mfpg_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mfpg_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mfpg_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                               m_tuser,
	input  logic                               cfg_we,
	input  logic [mfpg_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [mfpg_pkg::CFG_DW-1:0]        cfg_wdata,
	input  mfpg_pkg::ctrl_cmd_t                cmd,
	output mfpg_pkg::dp_sts_t                  sts
);

	localparam int F = mfpg_pkg::FRAC_BITS;
	localparam int W = mfpg_pkg::SAT_W;

	logic [30:0]              target_q;
	logic signed [17:0]       dir_q [3];
	logic signed [31:0]       init_grad_q;

	logic [63:0]              vol_sum_q;
	logic signed [63:0]       spd_sum_q;
	logic [63:0]              coef_sum_q;
	logic signed [31:0]       grad_q;
	logic signed [31:0]       inc_q;

	logic [30:0]              vol_q;
	logic [30:0]              rua_q;
	logic signed [31:0]       vel_q [3];
	logic signed [49:0]       mul_q [3];
	logic signed [31:0]       spd_q;
	logic signed [62:0]       sc1_q;
	logic [61:0]              sc2_q;
	logic signed [31:0]       t_q;
	logic signed [31:0]       ovel_q [3];
	logic                     status_q;
	logic [63:0]              mcoef_q;
	logic signed [33:0]       diff_q;
	logic                     out_vld_q;
	logic [mfpg_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                     out_user_q;

	logic signed [31:0]       mul_b;
	logic signed [49:0]       mul_p [3];
	logic signed [W-1:0]      dot;
	logic signed [31:0]       sc_a;
	logic [30:0]              sc_b;
	logic signed [64:0]       spd65;
	logic [64:0]              vol65;
	logic [64:0]              coef65;
	logic [63:0]              spd_mag;
	logic [33:0]              diff_mag;
	logic [63:0]              div_num;
	logic [63:0]              div_den;
	logic                     div_busy;
	logic [63:0]              quot;
	logic signed [31:0]       mean;
	logic signed [31:0]       inc_new;
	logic signed [31:0]       src [3];

	mfpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_comb begin
		case (cmd.mul_sel)
			mfpg_pkg::MSEL_VEL: mul_b = 32'sd0;
			mfpg_pkg::MSEL_T: mul_b = t_q;
			mfpg_pkg::MSEL_GRAD: mul_b = grad_q;
			default: mul_b = 32'sd0;
		endcase
	end

	// velocity operand is per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.mul_sel == mfpg_pkg::MSEL_VEL) begin
				mul_p[i] = dir_q[i] * vel_q[i];
			end else begin
				mul_p[i] = dir_q[i] * mul_b;
			end
			src[i] = mfpg_pkg::sat32(W'(mul_q[i] >>> F));
		end
	end

	assign dot = W'(mul_q[0]) + W'(mul_q[1]) + W'(mul_q[2]);
	assign sc_a = cmd.sc_cor ? inc_q : spd_q;
	assign sc_b = cmd.sc_cor ? rua_q : vol_q;

	assign spd65 = $signed({spd_sum_q[63], spd_sum_q}) + 65'(sc1_q >>> F);
	assign vol65 = {1'b0, vol_sum_q} + 65'(vol_q);
	assign coef65 = {1'b0, coef_sum_q} + 65'(sc2_q >> F);

	assign spd_mag = spd_sum_q[63] ? (64'd0 - spd_sum_q) : spd_sum_q;
	assign diff_mag = diff_q[33] ? (34'd0 - diff_q) : diff_q;

	always_comb begin
		case (cmd.div_sel)
			mfpg_pkg::DSEL_COEF: begin
				div_num = coef_sum_q;
				div_den = vol_sum_q;
			end
			mfpg_pkg::DSEL_MEAN: begin
				div_num = spd_mag;
				div_den = vol_sum_q;
			end
			mfpg_pkg::DSEL_INC: begin
				div_num = 64'(diff_mag);
				div_den = mcoef_q;
			end
			default: begin
				div_num = coef_sum_q;
				div_den = vol_sum_q;
			end
		endcase
	end

	assign mean = mfpg_pkg::sdiv_sat(quot, spd_sum_q[63]);
	assign inc_new = mfpg_pkg::sdiv_sat(quot, diff_q[33]);

	// config registers and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			dir_q[0] <= mfpg_pkg::DIR_X_RST;
			dir_q[1] <= '0;
			dir_q[2] <= '0;
			init_grad_q <= '0;
			vol_sum_q <= '0;
			spd_sum_q <= '0;
			coef_sum_q <= '0;
			grad_q <= '0;
			inc_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					mfpg_pkg::REG_TARGET: target_q <= cfg_wdata[30:0];
					mfpg_pkg::REG_DIR_X: dir_q[0] <= $signed(cfg_wdata[17:0]);
					mfpg_pkg::REG_DIR_Y: dir_q[1] <= $signed(cfg_wdata[17:0]);
					mfpg_pkg::REG_DIR_Z: dir_q[2] <= $signed(cfg_wdata[17:0]);
					mfpg_pkg::REG_INIT_GRAD: init_grad_q <= $signed(cfg_wdata);
					default: ;
				endcase
			end
			if (cmd.acc_add) begin
				vol_sum_q <= vol65[64] ? '1 : vol65[63:0];
				coef_sum_q <= coef65[64] ? '1 : coef65[63:0];
				if (spd65[64] != spd65[63]) begin
					spd_sum_q <= spd65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				end else begin
					spd_sum_q <= spd65[63:0];
				end
			end
			if (cmd.upd) begin
				inc_q <= inc_new;
				grad_q <= mfpg_pkg::sat32(W'(grad_q) + W'(inc_new));
			end
			if (cmd.err) begin
				inc_q <= '0;
			end
			if (cmd.restart) begin
				grad_q <= init_grad_q;
				inc_q <= '0;
			end
			if (cmd.upd || cmd.err || cmd.restart) begin
				vol_sum_q <= '0;
				spd_sum_q <= '0;
				coef_sum_q <= '0;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// working registers of one word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vol_q <= s_tdata[30:0];
			vel_q[0] <= $signed(s_tdata[62:31]);
			vel_q[1] <= $signed(s_tdata[94:63]);
			vel_q[2] <= $signed(s_tdata[126:95]);
			rua_q <= s_tdata[157:127];
			status_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ovel_q[i] <= '0;
			end
		end
		if (cmd.err) begin
			status_q <= 1'b1;
		end
		if (cmd.mul_en) begin
			for (int i = 0; i < 3; i++) begin
				mul_q[i] <= mul_p[i];
			end
		end
		if (cmd.ld_spd) begin
			spd_q <= mfpg_pkg::sat32(dot >>> F);
		end
		if (cmd.ld_sc) begin
			sc1_q <= sc_a * $signed({1'b0, sc_b});
			sc2_q <= rua_q * vol_q;
		end
		if (cmd.ld_t) begin
			t_q <= mfpg_pkg::sat32(W'(sc1_q >>> F));
		end
		if (cmd.ld_ovel) begin
			for (int i = 0; i < 3; i++) begin
				ovel_q[i] <= mfpg_pkg::sat32(W'(vel_q[i]) + W'(mul_q[i] >>> F));
			end
		end
		if (cmd.ld_mcoef) begin
			mcoef_q <= quot;
		end
		if (cmd.ld_diff) begin
			diff_q <= $signed({3'b000, target_q}) - 34'(mean);
		end
		if (cmd.out_load) begin
			out_data_q <= {src[2], src[1], src[0], inc_q, grad_q, ovel_q[2], ovel_q[1], ovel_q[0]};
			out_user_q <= status_q;
		end
	end

	assign sts.item_cmd = mfpg_pkg::cmd_code_t'(s_tuser);
	assign sts.vol_zero = (vol_sum_q == '0);
	assign sts.quot_zero = (quot == '0);
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result word not presented");

endmodule

// ===== sv/mfpg_ctrl.sv =====
// controller state machine sequencing accumulate, finish, correct and restart words
`timescale 1ns / 1ps
module mfpg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  mfpg_pkg::dp_sts_t     sts,
	output mfpg_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [20:0] {
		S_IDLE     = 21'h000001,
		S_ACC_MUL  = 21'h000002,
		S_ACC_SPD  = 21'h000004,
		S_ACC_MUL2 = 21'h000008,
		S_ACC_ADD  = 21'h000010,
		S_FIN_CHK  = 21'h000020,
		S_FIN_DIV1 = 21'h000040,
		S_FIN_CHK2 = 21'h000080,
		S_FIN_DIV2 = 21'h000100,
		S_FIN_DIFF = 21'h000200,
		S_FIN_GO3  = 21'h000400,
		S_FIN_DIV3 = 21'h000800,
		S_FIN_UPD  = 21'h001000,
		S_FIN_ERR  = 21'h002000,
		S_COR_MUL  = 21'h004000,
		S_COR_T    = 21'h008000,
		S_COR_MUL2 = 21'h010000,
		S_COR_ADD  = 21'h020000,
		S_RESTART  = 21'h040000,
		S_SRC_MUL  = 21'h080000,
		S_DONE     = 21'h100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = mfpg_pkg::MSEL_VEL;
		cmd.div_sel = mfpg_pkg::DSEL_COEF;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					case (sts.item_cmd)
						mfpg_pkg::CMD_ACC: state_d = S_ACC_MUL;
						mfpg_pkg::CMD_FIN: state_d = S_FIN_CHK;
						mfpg_pkg::CMD_COR: state_d = S_COR_MUL;
						mfpg_pkg::CMD_RST: state_d = S_RESTART;
						default: state_d = S_RESTART;
					endcase
				end
			end
			S_ACC_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = mfpg_pkg::MSEL_VEL;
				state_d = S_ACC_SPD;
			end
			S_ACC_SPD: begin
				cmd.ld_spd = 1'b1;
				state_d = S_ACC_MUL2;
			end
			S_ACC_MUL2: begin
				cmd.ld_sc = 1'b1;
				state_d = S_ACC_ADD;
			end
			S_ACC_ADD: begin
				cmd.acc_add = 1'b1;
				state_d = S_SRC_MUL;
			end
			S_FIN_CHK: begin
				if (sts.vol_zero) begin
					state_d = S_FIN_ERR;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = mfpg_pkg::DSEL_COEF;
					state_d = S_FIN_DIV1;
				end
			end
			S_FIN_DIV1: begin
				if (!sts.div_busy) begin
					state_d = S_FIN_CHK2;
				end
			end
			S_FIN_CHK2: begin
				if (sts.quot_zero) begin
					state_d = S_FIN_ERR;
				end else begin
					cmd.ld_mcoef = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel = mfpg_pkg::DSEL_MEAN;
					state_d = S_FIN_DIV2;
				end
			end
			S_FIN_DIV2: begin
				if (!sts.div_busy) begin
					state_d = S_FIN_DIFF;
				end
			end
			S_FIN_DIFF: begin
				cmd.ld_diff = 1'b1;
				state_d = S_FIN_GO3;
			end
			S_FIN_GO3: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = mfpg_pkg::DSEL_INC;
				state_d = S_FIN_DIV3;
			end
			S_FIN_DIV3: begin
				if (!sts.div_busy) begin
					state_d = S_FIN_UPD;
				end
			end
			S_FIN_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_SRC_MUL;
			end
			S_FIN_ERR: begin
				cmd.err = 1'b1;
				state_d = S_SRC_MUL;
			end
			S_COR_MUL: begin
				cmd.ld_sc = 1'b1;
				cmd.sc_cor = 1'b1;
				state_d = S_COR_T;
			end
			S_COR_T: begin
				cmd.ld_t = 1'b1;
				state_d = S_COR_MUL2;
			end
			S_COR_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = mfpg_pkg::MSEL_T;
				state_d = S_COR_ADD;
			end
			S_COR_ADD: begin
				cmd.ld_ovel = 1'b1;
				state_d = S_SRC_MUL;
			end
			S_RESTART: begin
				cmd.restart = 1'b1;
				state_d = S_SRC_MUL;
			end
			S_SRC_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = mfpg_pkg::MSEL_GRAD;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result word overwritten before taken");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while one is in work");

endmodule
